@@ rtl/core/multiset_intersection_counter_core_assert.svh @@
// assertion macros for the multiset intersection counter
// no dependencies; included by mic_datapath, the module that carries checks
`ifndef MULTISET_INTERSECTION_COUNTER_CORE_ASSERT_SVH
`define MULTISET_INTERSECTION_COUNTER_CORE_ASSERT_SVH

// check sampled on the rising clock, suspended while reset is low
`define MIC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("mic assertion failed");

// check sampled on the rising clock, also during reset
`define MIC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("mic assertion failed");

`endif

@@ rtl/core/mic_pkg.sv @@
// shared types, codes and defaults of the multiset intersection counter
// no dependencies
package mic_pkg;

  localparam int unsigned TableEntries = 1024;
  localparam int unsigned CountBits    = 16;
  localparam int unsigned KeyBits      = 32;
  localparam int unsigned EpochBits    = 4;

  typedef enum logic [1:0] {
    OP_COUNT = 2'd0,
    OP_PROBE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOKUP,
    ST_CHECK
  } state_e;

  typedef struct packed {
    logic load;
    logic init_step;
    logic rd;
    logic fire;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    op_e  in_op;
    logic hit;
    logic empty;
    logic last;
    logic emit;
    logic out_busy;
    logic epoch_max;
    logic init_last;
  } dp_sts_t;

endpackage

@@ rtl/core/mic_stream_if.sv @@
// input and output channel interfaces of the multiset intersection counter
// depends on nothing but plain logic types
interface mic_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic signed [31:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface mic_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value_res;
  logic               status;

  modport source (output valid, output value_res, output status, input ready);
  modport sink   (input valid, input value_res, input status, output ready);
endinterface

@@ rtl/core/mic_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module mic_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/mic_ctrl.sv @@
// sequencing state machine of the multiset intersection counter
// depends on mic_pkg
module mic_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  mic_pkg::dp_sts_t sts_i,
  output logic             in_ready_o,
  output mic_pkg::dp_cmd_t cmd_o
);

  mic_pkg::state_e state_q, state_d;
  logic            done;

  assign done = sts_i.hit || sts_i.empty || sts_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mic_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mic_pkg::ST_INIT: begin
        if (sts_i.init_last) state_d = mic_pkg::ST_IDLE;
      end
      mic_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (sts_i.in_op)
            mic_pkg::OP_COUNT, mic_pkg::OP_PROBE: state_d = mic_pkg::ST_LOOKUP;
            mic_pkg::OP_CLEAR: begin
              if (sts_i.epoch_max) state_d = mic_pkg::ST_INIT;
            end
            default: state_d = mic_pkg::ST_IDLE;
          endcase
        end
      end
      mic_pkg::ST_LOOKUP: state_d = mic_pkg::ST_CHECK;
      mic_pkg::ST_CHECK: begin
        if (!done) begin
          state_d = mic_pkg::ST_LOOKUP;
        end else if (!(sts_i.emit && sts_i.out_busy)) begin
          state_d = mic_pkg::ST_IDLE;
        end
      end
      default: state_d = mic_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      mic_pkg::ST_INIT: cmd_o.init_step = 1'b1;
      mic_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      mic_pkg::ST_LOOKUP: cmd_o.rd = 1'b1;
      mic_pkg::ST_CHECK: begin
        cmd_o.advance = !done;
        cmd_o.fire    = done && !(sts_i.emit && sts_i.out_busy);
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ rtl/core/mic_datapath.sv @@
// table datapath: hashing, probe pointer, fill count, epoch and result register
// depends on mic_pkg, mic_ram and the assertion header
`include "multiset_intersection_counter_core_assert.svh"
module mic_datapath #(
  parameter int unsigned TableEntries = mic_pkg::TableEntries,
  parameter int unsigned CountBits    = mic_pkg::CountBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mic_pkg::dp_cmd_t   cmd_i,
  output mic_pkg::dp_sts_t   sts_o,
  input  logic [1:0]         in_operation_i,
  input  logic signed [31:0] in_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_value_res_o,
  output logic               out_status_o
);

  localparam int unsigned IdxW   = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned UsedW  = $clog2(TableEntries + 1);
  localparam int unsigned KeyW   = mic_pkg::KeyBits;
  localparam int unsigned EpW    = mic_pkg::EpochBits;
  localparam int unsigned WordW  = EpW + CountBits + KeyW;
  localparam logic [IdxW-1:0]      LastIdx  = IdxW'(TableEntries - 1);
  localparam logic [UsedW-1:0]     FullUsed = UsedW'(TableEntries);
  localparam logic [CountBits-1:0] CntMax   = '1;
  localparam logic [EpW-1:0]       EpMax    = '1;
  localparam logic [EpW-1:0]       EpFirst  = EpW'(1);

  // fold the key down to an index, then bring it below the table size
  function automatic logic [IdxW-1:0] hash_idx(input logic [KeyW-1:0] key);
    logic [IdxW-1:0] h;
    logic [IdxW:0]   r;
    h = '0;
    for (int i = 0; i < KeyW; i++) begin
      h[i % IdxW] = h[i % IdxW] ^ key[i];
    end
    r = {1'b0, h};
    if (r >= (IdxW+1)'(TableEntries)) r = r - (IdxW+1)'(TableEntries);
    return r[IdxW-1:0];
  endfunction

  mic_pkg::op_e          op_q;
  logic [KeyW-1:0]       key_q;
  logic [IdxW-1:0]       idx_q, idx_next;
  logic [IdxW-1:0]       probes_q;
  logic [UsedW-1:0]      used_q;
  logic [EpW-1:0]        epoch_q;
  logic [IdxW-1:0]       init_idx_q;
  logic                  out_valid_q;
  logic [KeyW-1:0]       out_value_q;
  logic                  out_status_q;

  logic [WordW-1:0]      rdata;
  logic [EpW-1:0]        rd_tag;
  logic [CountBits-1:0]  rd_cnt;
  logic [KeyW-1:0]       rd_key;
  logic                  hit, empty, emit, cnt_zero;
  logic                  we;
  logic [IdxW-1:0]       waddr;
  logic [WordW-1:0]      wdata;
  logic [CountBits-1:0]  new_cnt;
  mic_pkg::op_e          in_op;

  assign in_op = mic_pkg::op_e'(in_operation_i);
  assign {rd_tag, rd_cnt, rd_key} = rdata;

  assign empty    = rd_tag != epoch_q;
  assign hit      = !empty && (rd_key == key_q);
  assign cnt_zero = rd_cnt == '0;
  assign emit     = ((op_q == mic_pkg::OP_COUNT) && !hit && !empty) ||
                    ((op_q == mic_pkg::OP_PROBE) && hit && !cnt_zero);
  assign idx_next = (idx_q == LastIdx) ? '0 : idx_q + IdxW'(1);

  always_comb begin
    new_cnt = CountBits'(1);
    we      = 1'b0;
    if (op_q == mic_pkg::OP_COUNT) begin
      new_cnt = hit ? ((rd_cnt == CntMax) ? rd_cnt : rd_cnt + CountBits'(1))
                    : CountBits'(1);
      we      = cmd_i.fire && (hit || empty);
    end else if (op_q == mic_pkg::OP_PROBE) begin
      new_cnt = rd_cnt - CountBits'(1);
      we      = cmd_i.fire && hit && !cnt_zero;
    end
    waddr = idx_q;
    wdata = {epoch_q, new_cnt, key_q};
    if (cmd_i.init_step) begin
      we    = 1'b1;
      waddr = init_idx_q;
      wdata = '0;
    end
  end

  mic_ram #(
    .Width (WordW),
    .Depth (TableEntries)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      epoch_q     <= EpFirst;
      init_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.init_step) begin
        init_idx_q <= (init_idx_q == LastIdx) ? '0 : init_idx_q + IdxW'(1);
        if (init_idx_q == LastIdx) epoch_q <= EpFirst;
      end
      if (cmd_i.load && (in_op == mic_pkg::OP_CLEAR)) begin
        used_q <= '0;
        if (epoch_q != EpMax) epoch_q <= epoch_q + EpW'(1);
      end
      if (cmd_i.fire && (op_q == mic_pkg::OP_COUNT) && !hit && empty) begin
        used_q <= used_q + UsedW'(1);
      end
      if (cmd_i.fire && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= in_op;
      key_q    <= in_value_i;
      idx_q    <= hash_idx(in_value_i);
      probes_q <= '0;
    end else if (cmd_i.advance) begin
      idx_q    <= idx_next;
      probes_q <= probes_q + IdxW'(1);
    end
    if (cmd_i.fire && emit) begin
      out_value_q  <= key_q;
      out_status_q <= (op_q == mic_pkg::OP_COUNT);
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.in_op     = in_op;
    sts_o.hit       = hit;
    sts_o.empty     = empty;
    sts_o.last      = probes_q == LastIdx;
    sts_o.emit      = emit;
    sts_o.out_busy  = out_valid_q && !out_ready_i;
    sts_o.epoch_max = epoch_q == EpMax;
    sts_o.init_last = init_idx_q == LastIdx;
  end

  assign out_valid_o     = out_valid_q;
  assign out_value_res_o = out_value_q;
  assign out_status_o    = out_status_q;

  `MIC_ASSERT(a_used_bound, clk_i, rst_ni, used_q <= FullUsed)
  `MIC_ASSERT(a_epoch_live, clk_i, rst_ni, epoch_q != '0)
  `MIC_ASSERT(a_no_overwrite, clk_i, rst_ni, (cmd_i.fire && emit) |-> !sts_o.out_busy)
  `MIC_ASSERT(a_init_epoch, clk_i, rst_ni,
    (cmd_i.init_step && (init_idx_q == LastIdx)) |=> (epoch_q == EpFirst))

endmodule

@@ rtl/core/multiset_intersection_counter_core.sv @@
// top level of the multiset intersection counter
// depends on mic_pkg, mic_stream_if, mic_ctrl, mic_datapath, mic_ram
//
//  channel  | dir | payload                         | transfer when
//  in_i     | in  | operation[1:0], value[31:0] s   | valid && ready
//  out_o    | out | value_res[31:0] s, status       | valid && ready
//
// count and probe walk the linear probe path from the hashed slot, one slot in
// a sparse table and up to TABLE_ENTRIES when full; each slot takes a
// registered ram read (LOOKUP) and then a check (CHECK)
// clear is done in the idle state; every 15th clear, and reset, start a pass
// over all TABLE_ENTRIES slots that blanks the epoch tags, input stalled
// a result waits in the output register; a new item is taken meanwhile and
// only a second result holds the block until the first is transferred
module multiset_intersection_counter_core #(
  parameter int unsigned TABLE_ENTRIES = mic_pkg::TableEntries,
  parameter int unsigned COUNT_BITS    = mic_pkg::CountBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mic_in_if.sink    in_i,
  mic_out_if.source out_o
);

  mic_pkg::dp_cmd_t cmd;
  mic_pkg::dp_sts_t sts;

  // sequencing of lookups, commits and the tag clearing pass
  mic_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .sts_i      (sts),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd)
  );

  // hashed table of value counts with output register
  mic_datapath #(
    .TableEntries (TABLE_ENTRIES),
    .CountBits    (COUNT_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_operation_i  (in_i.operation),
    .in_value_i      (in_i.value),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .out_value_res_o (out_o.value_res),
    .out_status_o    (out_o.status)
  );

endmodule

@@ bench/mic_tb_if.sv @@
// bench helper package used by the bench around the multiset intersection counter
// depends on nothing; holds the expected result record of the output channel
// (the block's interfaces are compiled from the rtl; this file only holds bench helpers)
package mic_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] value_res;
    logic               status;
  } match_t;
endpackage

@@ bench/tb_top.sv @@
// self-checking bench for multiset_intersection_counter_core
// depends on the core, mic_pkg, mic_stream_if (rtl) and mic_tb_pkg; counts, probes and
// clears are predicted against a shadow count table and each result is compared in order
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mic_pkg::*;
  import mic_tb_pkg::*;

  localparam int unsigned Entries  = TableEntries;
  localparam int unsigned CountMax = (1 << CountBits) - 1;
  localparam int unsigned WdLimit  = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mic_in_if  in_ch ();
  mic_out_if out_ch ();

  multiset_intersection_counter_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the count table: associative by value, order of slots never shows
  int unsigned shadow_count [logic [31:0]];
  int unsigned shadow_used;

  match_t matches_due [$];
  int unsigned errors;
  int unsigned idle_cycles;

  // recent values kept so probes and recounts hit stored entries
  logic [31:0] pool [$];

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  // works out the result of one transferred item
  function automatic void predict_match(input op_e op, input logic [31:0] v);
    match_t m;
    case (op)
      OP_COUNT: begin
        if (shadow_count.exists(v)) begin
          if (shadow_count[v] < CountMax) shadow_count[v]++;
        end else if (shadow_used >= Entries) begin
          // full table: value dropped, full status back
          m.value_res = v;
          m.status    = 1'b1;
          matches_due = {matches_due, m};
        end else begin
          shadow_count[v] = 1;
          shadow_used++;
        end
      end
      OP_PROBE: begin
        if (shadow_count.exists(v) && shadow_count[v] > 0) begin
          shadow_count[v]--;
          m.value_res = v;
          m.status    = 1'b0;
          matches_due = {matches_due, m};
        end
      end
      OP_CLEAR: begin
        shadow_count.delete();
        shadow_used = 0;
      end
      default: ;  // unused code leaves everything alone
    endcase
  endfunction

  // one transfer on the input channel after a random gap
  task automatic send_item(input op_e op, input logic [31:0] v, input bit gaps = 1'b1);
    int unsigned gap;
    gap = gaps ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19)) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.value     <= v;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    predict_match(op, v);
    if (pool.size() > 64) void'(pool.pop_front());
    pool = {pool, v};
  endtask

  task automatic drop_valid();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    drop_valid();
    while (matches_due.size() != 0) @(posedge clk_i);
    // a count or clear with no result may still be busy; allow for a probe walk
    repeat (2 * Entries + 8) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    if (pool.size() != 0 && $urandom_range(0, 3) != 0)
      return pool[$urandom_range(0, pool.size() - 1)];
    return $urandom_range(0, 15) == 0 ? $urandom() : $urandom_range(0, 40);
  endfunction

  // extremes of the value field, miss, zero count, unused code
  task automatic test_directed();
    send_item(OP_COUNT, 32'h8000_0000);
    send_item(OP_COUNT, 32'h7fff_ffff);
    send_item(OP_COUNT, 32'hffff_ffff);
    send_item(OP_COUNT, 32'h0000_0000);
    send_item(OP_COUNT, 32'h7fff_ffff);
    send_item(OP_PROBE, 32'h8000_0000);
    send_item(OP_PROBE, 32'h8000_0000);   // count now zero, no match
    send_item(OP_PROBE, 32'h7fff_ffff);
    send_item(OP_PROBE, 32'h7fff_ffff);
    send_item(OP_PROBE, 32'h1234_5678);   // never stored
    send_item(OP_NONE,  32'hffff_ffff);
    send_item(OP_PROBE, 32'hffff_ffff);
    send_item(OP_PROBE, 32'h0000_0000);
    send_item(OP_COUNT, 32'h8000_0000);   // zero-count entry counts again
    send_item(OP_PROBE, 32'h8000_0000);
    send_item(OP_CLEAR, 32'h5555_5555);
    send_item(OP_PROBE, 32'h0000_0000);   // cleared, no match
    send_item(OP_COUNT, 32'haaaa_aaaa);
    send_item(OP_PROBE, 32'haaaa_aaaa);
    wait_drained();
  endtask

  // fill every slot, then new values come back with full status
  task automatic test_full_table();
    send_item(OP_CLEAR, 32'h0);
    for (int unsigned i = 0; i < Entries; i++) send_item(OP_COUNT, 32'h1000 + i, 1'b0);
    for (int unsigned i = 0; i < 6; i++) send_item(OP_COUNT, $urandom() | 32'h8000_0000);
    send_item(OP_COUNT, 32'h1000);        // stored value still counts
    send_item(OP_PROBE, 32'h1000);
    send_item(OP_PROBE, 32'h13ff);
    send_item(OP_CLEAR, 32'h0);
    wait_drained();
  endtask

  // random mix of counts and probes, some noise and clears
  task automatic test_random();
    int unsigned r;
    for (int unsigned n = 0; n < 290; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45)      send_item(OP_COUNT, pick_value());
      else if (r < 90) send_item(OP_PROBE, pick_value());
      else if (r < 94) send_item(OP_NONE, $urandom());
      else if (r < 97) send_item(OP_CLEAR, $urandom());
      else             send_item(OP_PROBE, $urandom());
      // hold off until the result queue has drained, once, after item 200
      if (n % 400 == 200) begin
        drop_valid();
        while (matches_due.size() != 0) @(posedge clk_i);
      end
    end
    drop_valid();
  endtask

  // result side: random stalls, in-order comparison
  initial begin
    int unsigned stall;
    match_t exp_m;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
      if (matches_due.size() == 0) begin
        report($sformatf("unexpected result value %h status %b",
                         out_ch.value_res, out_ch.status));
      end else begin
        exp_m = matches_due.pop_front();
        if (out_ch.value_res !== exp_m.value_res)
          report($sformatf("value_res %h, want %h", out_ch.value_res, exp_m.value_res));
        if (out_ch.status !== exp_m.status)
          report($sformatf("status %b, want %b for %h", out_ch.status, exp_m.status,
                           exp_m.value_res));
      end
    end
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WdLimit) begin
      $display("** multiset_intersection_counter_core: FAILED **");
      $finish;
    end
  end

  initial begin
    errors      = 0;
    idle_cycles = 0;
    shadow_used = 0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_NONE;
    in_ch.value     <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_table();
    test_random();
    wait_drained();
    if (errors == 0 && matches_due.size() == 0) begin
      $display("** multiset_intersection_counter_core: PASSED **");
    end else begin
      if (matches_due.size() != 0) report("results missing at end");
      $display("** multiset_intersection_counter_core: FAILED **");
    end
    $finish;
  end
endmodule
